### src/irenc_pkg.sv
// ----------------------------------------------------------------------------
// irenc_pkg
// Types and constant tables shared by the roman numeral encoder modules.
// ----------------------------------------------------------------------------
package irenc_pkg;

    localparam int VALUE_W  = 12;
    localparam int CHAR_W   = 8;
    localparam int ROWS     = 13;
    localparam int ROW_W    = 4;
    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd3999;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [ROW_W-1:0]   row_t;

    localparam char_t CH_NONE = 8'h00;
    localparam char_t CH_M    = 8'h4D;
    localparam char_t CH_D    = 8'h44;
    localparam char_t CH_C    = 8'h43;
    localparam char_t CH_L    = 8'h4C;
    localparam char_t CH_X    = 8'h58;
    localparam char_t CH_V    = 8'h56;
    localparam char_t CH_I    = 8'h49;

    // greedy rows, largest weight first, subtractive pairs in between
    localparam value_t SYM_WEIGHT [ROWS] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam char_t SYM_FIRST [ROWS] = '{
        CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
    };
    localparam char_t SYM_SECOND [ROWS] = '{
        CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L, CH_NONE,
        CH_X, CH_NONE, CH_V, CH_NONE
    };

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // status of the queue between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // first row whose weight fits in the remainder
    function automatic row_t find_row(input value_t rem);
        row_t row;
        row = row_t'(ROWS - 1);
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (SYM_WEIGHT[i] <= rem)
            begin
                row = row_t'(i);
            end
        end
        return row;
    endfunction

    function automatic logic value_ok(input value_t v);
        return (v != '0) && (v <= VALUE_LIMIT);
    endfunction

endpackage

### src/irenc_fifo.sv
// ----------------------------------------------------------------------------
// irenc_fifo
// Small register queue between the front and the back of the encoder.
// ----------------------------------------------------------------------------
module irenc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  irenc_pkg::value_t         wr_data,
    input  logic                      rd_en,
    output irenc_pkg::value_t         rd_data,
    output irenc_pkg::q_status_t      status
);
    import irenc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    value_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_wr, do_rd;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");
`endif

endmodule

### src/irenc_front.sv
// ----------------------------------------------------------------------------
// irenc_front
// Input stage: takes words, drops values with an empty numeral or out of range.
// ----------------------------------------------------------------------------
module irenc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  irenc_pkg::value_t     value,
    output logic                  q_wr,
    output irenc_pkg::value_t     q_data,
    input  irenc_pkg::q_status_t  q_status
);
    import irenc_pkg::*;

    logic   stage_valid_reg, stage_valid_next;
    value_t stage_value_reg;
    logic   load;

    assign full   = stage_valid_reg && q_status.full;
    assign load   = push && !full;
    assign q_wr   = stage_valid_reg && !q_status.full;
    assign q_data = stage_value_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (load)
        begin
            stage_valid_next = value_ok(value);
        end
        else if (q_wr)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_value_reg <= value;
        end
    end

endmodule

### src/irenc_back.sv
// ----------------------------------------------------------------------------
// irenc_back
// Sequencer: reduces one value greedily and emits one character per cycle while the output is free or popped.
// ----------------------------------------------------------------------------
module irenc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  q_rd,
    input  irenc_pkg::value_t     q_data,
    input  irenc_pkg::q_status_t  q_status,
    output logic                  empty,
    input  logic                  pop,
    output irenc_pkg::char_t      symbol_char,
    output logic                  last_char
);
    import irenc_pkg::*;

    state_t state_reg, state_next;
    value_t rem_reg, rem_next;
    char_t  pending_reg, pending_next;
    logic   out_valid_reg, out_valid_next;
    char_t  sym_reg, sym_next;
    logic   last_reg, last_next;

    row_t   row;
    value_t rem_sub;
    logic   emit;

    assign row         = find_row(rem_reg);
    assign rem_sub     = rem_reg - SYM_WEIGHT[row];
    assign emit        = (state_reg == ST_RUN) && (!out_valid_reg || pop);
    assign empty       = !out_valid_reg;
    assign symbol_char = sym_reg;
    assign last_char   = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg && !pop;
        sym_next       = sym_reg;
        last_next      = last_reg;
        q_rd           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_rd         = 1'b1;
                    rem_next     = q_data;
                    pending_next = CH_NONE;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    if (pending_reg != CH_NONE)
                    begin
                        // second half of a subtractive pair
                        sym_next     = pending_reg;
                        last_next    = (rem_reg == '0);
                        pending_next = CH_NONE;
                    end
                    else
                    begin
                        sym_next     = SYM_FIRST[row];
                        last_next    = (SYM_SECOND[row] == CH_NONE) && (rem_sub == '0);
                        pending_next = SYM_SECOND[row];
                        rem_next     = rem_sub;
                    end
                    if (last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        pending_reg <= pending_next;
        sym_reg     <= sym_next;
        last_reg    <= last_next;
    end

`ifndef SYNTHESIS
    a_run_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rem_reg != '0) || (pending_reg != CH_NONE))
        else $error("sequencer running with nothing left");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_next |=> (state_reg == ST_IDLE))
        else $error("sequencer did not stop after last character");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sym_reg == CH_M) || (sym_reg == CH_D) || (sym_reg == CH_C)
            || (sym_reg == CH_L) || (sym_reg == CH_X) || (sym_reg == CH_V)
            || (sym_reg == CH_I))
        else $error("output character not a numeral symbol");
`endif

endmodule

### src/integer_to_roman_encoder_top.sv
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top
// Converts values 1 to 3999 into Roman numeral ASCII characters, one per word.
// ----------------------------------------------------------------------------
// usage
//   input channel: drive value and raise push; the word is taken at a clock
//   edge with push high and full low. values of 0 or above 3999 are taken
//   and dropped, they give no characters
//   output channel: while empty is low, symbol_char holds the oldest
//   character and last_char marks the final character of a numeral; pop
//   high with empty low takes it
//   path: the first character of a value passes the input register, the
//   queue, the sequencer load and the output register before it shows up
//   sequencing: the sequencer loads a value in its idle state, then emits
//   one character per cycle while pop keeps up; the longest numeral has
//   fifteen characters; the front keeps taking values into the queue while
//   the sequencer works
//   stall: when pop stays low the character waits in the output register,
//   the sequencer holds, the queue fills and then full rises
//   reset: rst_n low clears the queue, the input register and the
//   sequencer at once; the block is empty and ready right after
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  irenc_pkg::value_t   value,
    output logic                empty,
    input  logic                pop,
    output irenc_pkg::char_t    symbol_char,
    output logic                last_char
);
    import irenc_pkg::*;

    // front to queue
    logic       q_wr;
    value_t     q_wr_data;
    // queue to back
    logic       q_rd;
    value_t     q_rd_data;
    q_status_t  q_status;

    // front: register the word, keep only values with a numeral
    irenc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .value    (value),
        .q_wr     (q_wr),
        .q_data   (q_wr_data),
        .q_status (q_status)
    );

    // decouples the front from the character sequencer
    irenc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .status  (q_status)
    );

    // back: greedy reduction, one character per cycle into a free or popped output register
    irenc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rd        (q_rd),
        .q_data      (q_rd_data),
        .q_status    (q_status),
        .empty       (empty),
        .pop         (pop),
        .symbol_char (symbol_char),
        .last_char   (last_char)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer to roman numeral encoder. Values go in
// through the push/full side, numeral characters are popped and compared
// in order against a digit-by-digit decomposition done in the bench.
// ----------------------------------------------------------------------------

// expected character store plus the decomposition that fills it
class roman_scoreboard;

    typedef struct packed {
        irenc_pkg::char_t ch_code;
        logic             is_last;
    } numeral_char_t;

    numeral_char_t expected_chars[$];
    int            mismatches;
    int            chars_checked;

    function new();
        mismatches    = 0;
        chars_checked = 0;
    endfunction

    function void put_char(irenc_pkg::char_t c);
        numeral_char_t nc;
        nc.ch_code = c;
        nc.is_last = 1'b0;
        expected_chars.push_back(nc);
    endfunction

    // one decimal digit with its unit, five and ten symbols
    function int put_digit(int d, irenc_pkg::char_t one, irenc_pkg::char_t five,
                           irenc_pkg::char_t ten);
        int n;
        n = 0;
        if (d == 9)
        begin
            put_char(one);
            put_char(ten);
            n = 2;
        end
        else if (d == 4)
        begin
            put_char(one);
            put_char(five);
            n = 2;
        end
        else
        begin
            if (d >= 5)
            begin
                put_char(five);
                n = 1;
                d = d - 5;
            end
            repeat (d)
            begin
                put_char(one);
                n++;
            end
        end
        return n;
    endfunction

    // called for every accepted word, returns the numeral length
    function int note_value(irenc_pkg::value_t v);
        int num;
        int n;
        num = int'(v);
        n   = 0;
        if (num == 0 || num > 3999)
        begin
            return 0;
        end
        repeat (num / 1000)
        begin
            put_char(irenc_pkg::CH_M);
            n++;
        end
        n += put_digit((num / 100) % 10, irenc_pkg::CH_C, irenc_pkg::CH_D, irenc_pkg::CH_M);
        n += put_digit((num / 10) % 10, irenc_pkg::CH_X, irenc_pkg::CH_L, irenc_pkg::CH_C);
        n += put_digit(num % 10, irenc_pkg::CH_I, irenc_pkg::CH_V, irenc_pkg::CH_X);
        expected_chars[$].is_last = 1'b1;
        return n;
    endfunction

    function void flag_error();
        mismatches++;
    endfunction

    function void check_char(irenc_pkg::char_t got_ch, logic got_last);
        numeral_char_t exp_c;
        if (expected_chars.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: unexpected char '%c' (%h) last=%b", $realtime, got_ch, got_ch,
                         got_last);
            end
            return;
        end
        exp_c = expected_chars.pop_front();
        chars_checked++;
        if (exp_c.ch_code !== got_ch || exp_c.is_last !== got_last)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t: char mismatch: expected '%c' (%h) last=%b, got '%c' (%h) last=%b",
                         $realtime, exp_c.ch_code, exp_c.ch_code, exp_c.is_last,
                         got_ch, got_ch, got_last);
            end
        end
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

endclass

module tb_top;

    import irenc_pkg::*;

    // clock and reset, every dut input known from time zero
    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    logic   push  = 1'b0;
    logic   pop   = 1'b0;
    value_t value = '0;
    logic   full;
    logic   empty;
    char_t  symbol_char;
    logic   last_char;

    always #10 clk = ~clk;

    integer_to_roman_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .value       (value),
        .empty       (empty),
        .pop         (pop),
        .symbol_char (symbol_char),
        .last_char   (last_char)
    );

    roman_scoreboard numerals = new();

    // idle rates in percent, changed per phase by the main sequence
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    // long receiver hold-off, requested by the main sequence, counted below
    int rx_hold_req  = 0;

    // run statistics for the closing summary
    int words_valid    = 0;
    int words_dropped  = 0;
    int longest_run    = 0;
    int full_cycles    = 0;

    // ------------------------------------------------------------------------
    // receiver: samples right after the edge, so it sees what the dut saw;
    // pop is decided once per cycle, long hold-offs are counted here
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                numerals.check_char(symbol_char, last_char);
            end
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------

    // offer one word and hold it until the block takes it; called at an edge
    task automatic send_value(input value_t v);
        int len;
        value <= v;
        push  <= 1'b1;
        @(posedge clk);
        while (full)
        begin
            full_cycles++;
            @(posedge clk);
        end
        len = numerals.note_value(v);
        if (len == 0)
        begin
            words_dropped++;
        end
        else
        begin
            words_valid++;
            if (len > longest_run)
            begin
                longest_run = len;
            end
        end
    endtask

    // random gap after a word; push drops only if at least one idle cycle
    task automatic idle_gap();
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // wait for every expected character, bounded so a hang still ends
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (numerals.pending() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    // digits drawn from 3, 7 and 8 give the long numerals
    function automatic value_t long_value();
        int digs [3];
        int v;
        digs = '{3, 7, 8};
        v = $urandom_range(1, 3) * 1000 + digs[$urandom_range(0, 2)] * 100
            + digs[$urandom_range(0, 2)] * 10 + digs[$urandom_range(0, 2)];
        return value_t'(v);
    endfunction

    // mostly legal values, some short, some long, a few that get dropped
    function automatic value_t random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return ($urandom_range(0, 1) == 0) ? value_t'(0)
                                                : value_t'($urandom_range(4000, 4095));
        end
        else if (r < 20)
        begin
            return value_t'($urandom_range(1, 30));
        end
        else if (r < 35)
        begin
            return long_value();
        end
        return value_t'($urandom_range(1, 3999));
    endfunction

    // send random words until n_legal of them produced characters
    task automatic run_phase(input int n_legal, input int tx_pct, input int rx_pct,
                             input int hold_cycles);
        int target;
        target      = words_valid + n_legal;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        rx_hold_req = hold_cycles;
        while (words_valid < target)
        begin
            send_value(random_value());
            idle_gap();
        end
        push <= 1'b0;
        // sender pauses here until the block has handed out everything
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        value_t directed [25];
        directed = '{
            12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888, 12'd4, 12'd9,
            12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50, 12'd500, 12'd1000,
            12'd3000, 12'd1994, 12'd2048, 12'd444, 12'd999, 12'd14, 12'd0, 12'd3,
            12'd1024
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: limits, every subtractive pair, dropped values,
        // the fifteen-character numeral, back to back
        foreach (directed[i])
        begin
            send_value(directed[i]);
        end
        push <= 1'b0;
        wait_drained();

        // slow receiver, then slow sender, then full speed with a long stall
        run_phase(105, 26, 69, 0);
        run_phase(105, 69, 26, 0);
        run_phase(95, 0, 0, 400);

        // let anything stray come out before the final tally
        repeat (40) @(posedge clk);

        if (numerals.pending() != 0)
        begin
            $display("%0d expected characters never arrived", numerals.pending());
            numerals.flag_error();
        end

        $display("converted %0d values (%0d dropped as zero or out of range), longest numeral %0d",
                 words_valid, words_dropped, longest_run);
        $display("checked %0d characters, input held off by full for %0d cycles, %0d mismatches",
                 numerals.chars_checked, full_cycles, numerals.mismatches);

        if (numerals.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legitimate run
    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### integer_to_roman_encoder_top.f
src/irenc_pkg.sv
src/irenc_fifo.sv
src/irenc_front.sv
src/irenc_back.sv
src/integer_to_roman_encoder_top.sv
tb/tb_top.sv
